// File: rtl/core/hpws_pkg.sv
// ----------------------------------------------------------------------------
// hpws_pkg
// Types and constants for the parity-protected word store: command codes,
// field widths and the layout of one group row (four data, three parity).
// ----------------------------------------------------------------------------
package hpws_pkg;

  localparam int NUM_WORDS   = 64;
  localparam int GROUP_COUNT = (NUM_WORDS + 3) / 4;

  localparam int CMD_W  = 2;
  localparam int WIDX_W = 6;
  localparam int WORD_W = 32;
  localparam int BIDX_W = 11;
  localparam int LANE_W = 5;                 // bit within a word
  localparam int ROW_W  = WIDX_W - 2;        // group address

  localparam int IN_DATA_W  = 56;            // 49 payload bits padded to bytes
  localparam int OUT_DATA_W = 8;             // 5 payload bits padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t [2:0] par;
    word_t [3:0] dat;
  } row_t;

endpackage

// File: rtl/core/hamming_parity_word_store.sv
// ----------------------------------------------------------------------------
// hamming_parity_word_store
// Word store in groups of four with three bitwise Hamming(7,4) parity words.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command on in_tuser: write a word, read one bit with
//   a parity check of its group, or clear the whole store. Every beat yields
//   exactly one result beat: read bit, parity error flag and 3-bit syndrome
//   (all zero for write and clear and for the unused command code).
//   The store is one row per group (four data words plus three parity
//   words, 224 bits) in a memory with one registered read and one write
//   port. The row is read as the beat is accepted; the cycle after, the
//   update or check is worked out and the result is registered. A write to
//   the row that the next beat reads is forwarded, so one beat per cycle is
//   sustained while the receiver takes every result.
//   Reset clears the per-row valid bits at once and an invalid row reads as
//   zero, so the block is ready in the first cycle after reset; the clear
//   command does the same. When the receiver stalls, the result is held and
//   the one item in flight waits; input is accepted again once the output
//   register can drain.
// ----------------------------------------------------------------------------
module hamming_parity_word_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [5:0] word_index, [37:6] word_value, [48:38] bit_index, rest zero
  input  logic [hpws_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] command
  input  logic [hpws_pkg::CMD_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] read_bit, [1] parity_error, [4:2] syndrome, rest zero
  output logic [hpws_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hpws_pkg::*;

  function automatic logic [2:0][WORD_W-1:0] parity_of(input word_t [3:0] d);
    logic [2:0][WORD_W-1:0] p;
    p[0] = d[1] ^ d[2] ^ d[3];
    p[1] = d[0] ^ d[2] ^ d[3];
    p[2] = d[0] ^ d[1] ^ d[3];
    return p;
  endfunction

  // input side
  cmd_t              in_cmd;
  logic [WIDX_W-1:0] in_widx;
  logic [WORD_W-1:0] in_wval;
  logic [BIDX_W-1:0] in_bidx;
  logic [ROW_W-1:0]  in_row;
  logic              in_fire;

  // stage 1
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [WIDX_W-1:0] s1_widx_r;
  logic [WORD_W-1:0] s1_wval_r;
  logic [BIDX_W-1:0] s1_bidx_r;
  row_t              rd_row_r;
  logic              rd_vld_r;
  logic              fwd_hit_r;
  row_t              fwd_row_r;
  logic              fwd_hit_nxt;
  row_t              fwd_row_nxt;

  row_t              mem [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] vld_r;

  logic              advance;
  logic              s1_fire;
  logic [ROW_W-1:0]  s1_row;
  row_t              cur_row;
  row_t              new_row;
  logic              wr_en;
  logic              clr_en;
  logic              rd_ok;
  logic              bit_nxt;
  logic [2:0]        syn_nxt;

  // output register
  logic              out_valid_r;
  logic              out_bit_r;
  logic              out_perr_r;
  logic [2:0]        out_syn_r;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_widx = in_tdata[5:0];
  assign in_wval = in_tdata[37:6];
  assign in_bidx = in_tdata[48:38];
  assign in_row  = (in_cmd == CMD_READ) ? in_bidx[BIDX_W-1:BIDX_W-ROW_W]
                                        : in_widx[WIDX_W-1:2];

  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_row  = (s1_cmd_r == CMD_READ) ? s1_bidx_r[BIDX_W-1:BIDX_W-ROW_W]
                                     : s1_widx_r[WIDX_W-1:2];
    cur_row = fwd_hit_r ? fwd_row_r : (rd_vld_r ? rd_row_r : '0);

    new_row = cur_row;
    new_row.dat[s1_widx_r[1:0]] = s1_wval_r;
    new_row.par = parity_of(new_row.dat);

    wr_en  = s1_fire && (s1_cmd_r == CMD_WRITE) && (32'(s1_widx_r) < NUM_WORDS);
    clr_en = s1_fire && (s1_cmd_r == CMD_CLEAR);
    rd_ok  = (s1_cmd_r == CMD_READ) &&
             (32'(s1_bidx_r[BIDX_W-1:LANE_W]) < NUM_WORDS);

    bit_nxt = 1'b0;
    syn_nxt = 3'b000;
    if (rd_ok) begin
      bit_nxt = cur_row.dat[s1_bidx_r[LANE_W+1:LANE_W]][s1_bidx_r[LANE_W-1:0]];
      syn_nxt[0] = (cur_row.dat[1] ^ cur_row.dat[2] ^ cur_row.dat[3]) != cur_row.par[0];
      syn_nxt[1] = (cur_row.dat[0] ^ cur_row.dat[2] ^ cur_row.dat[3]) != cur_row.par[1];
      syn_nxt[2] = (cur_row.dat[0] ^ cur_row.dat[1] ^ cur_row.dat[3]) != cur_row.par[2];
    end

    // the memory read at this edge misses the update landing at the same edge
    fwd_hit_nxt = clr_en || (wr_en && (in_row == s1_row));
    fwd_row_nxt = clr_en ? '0 : new_row;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_row] <= new_row;
    end
    if (in_fire) begin
      rd_row_r  <= mem[in_row];
      rd_vld_r  <= vld_r[in_row];
      fwd_hit_r <= fwd_hit_nxt;
      fwd_row_r <= fwd_row_nxt;
      s1_cmd_r  <= in_cmd;
      s1_widx_r <= in_widx;
      s1_wval_r <= in_wval;
      s1_bidx_r <= in_bidx;
    end
    if (s1_fire) begin
      out_bit_r  <= bit_nxt;
      out_perr_r <= (syn_nxt != 3'b000);
      out_syn_r  <= syn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_en) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[s1_row] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-5){1'b0}}, out_syn_r, out_perr_r, out_bit_r};

`ifndef NO_ASSERTIONS
  // parity is always rebuilt from stored words, so a check never fails
  a_no_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:2] == 3'b000))
    else $error("nonzero syndrome on a consistent store");

  a_clear_drops_rows: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |=> (vld_r == '0))
    else $error("clear left a row valid");

  a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(s1_row)])
    else $error("written row not marked valid");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r && $stable(s1_cmd_r))
    else $error("stage 1 item lost during stall");
`endif

endmodule
